// ----- hdl/tlru_pkg.sv -----
`timescale 1ns / 1ps

package tlru_pkg;

    localparam int ENTRIES  = 8;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int ADDR_W   = 32;
    localparam int PAGE_W   = 20;
    localparam int OFFSET_W = 12;

    typedef struct packed {
        logic [PAGE_W-1:0] tag;
        logic [IDX_W-1:0]  rank;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESULT
    } state_t;

endpackage

// ----- hdl/tlb_lookup_lru_replace_core.sv -----
`timescale 1ns / 1ps

// Fully associative page tag store with least-recently-used replacement.
// Input channel: virtual_address is taken at a rising edge with start high
// and busy low. The address splits into a 20-bit page number and a 12-bit
// offset. Output channel: done pulses for exactly one cycle with hit,
// vpn, page_offset, evicted and slot; the receiver must take it then.
// Tags and recency ranks share one entry memory with a registered read port
// and one write port. An item first walks the valid entries (one read per
// cycle, compare and oldest-entry search on the returned data), then decides
// the slot, then walks the entries again as read-modify-write to age ranks
// and install the tag. The item passes through the scan, decide, update and
// result states in that order, and done is raised in the result state. busy
// drops in the cycle after done, so the next item can be taken then. The two
// memory walks set the throughput.
// Reset empties the store at once (entry count to zero); no clearing pass.
// Configuration: none.
module tlb_lookup_lru_replace_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tlru_pkg::ADDR_W-1:0]    virtual_address,
    output logic                           done,
    output logic                           hit,
    output logic [tlru_pkg::PAGE_W-1:0]    vpn,
    output logic [tlru_pkg::OFFSET_W-1:0]  page_offset,
    output logic                           evicted,
    output logic [tlru_pkg::IDX_W-1:0]     slot
);
    import tlru_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               rvld_reg, rvld_next;
    logic [IDX_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hslot_reg, hslot_next;
    logic [IDX_W-1:0]   hrank_reg, hrank_next;
    logic [IDX_W-1:0]   worst_idx_reg, worst_idx_next;
    logic [IDX_W-1:0]   worst_rank_reg, worst_rank_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic               evicted_reg, evicted_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [PAGE_W-1:0]  page;
    logic               full;

    assign page = addr_reg[ADDR_W-1 -: PAGE_W];
    assign full = (count_reg == CNT_W'(ENTRIES));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rvld_reg    <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rvld_reg    <= rvld_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        rd_addr_reg    <= rd_addr_next;
        hit_reg        <= hit_next;
        hslot_reg      <= hslot_next;
        hrank_reg      <= hrank_next;
        worst_idx_reg  <= worst_idx_next;
        worst_rank_reg <= worst_rank_next;
        slot_reg       <= slot_next;
        limit_reg      <= limit_next;
        evicted_reg    <= evicted_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        rvld_next       = 1'b0;
        rd_addr_next    = rd_addr_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        hslot_next      = hslot_reg;
        hrank_next      = hrank_reg;
        worst_idx_next  = worst_idx_reg;
        worst_rank_next = worst_rank_reg;
        slot_next       = slot_reg;
        limit_next      = limit_reg;
        evicted_next    = evicted_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = rd_addr_reg;
        wr_data         = rdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    addr_next  = virtual_address;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rvld_next    = 1'b1;
                    rd_addr_next = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
                if (rvld_reg)
                begin
                    if (!hit_reg && rdata_reg.tag == page)
                    begin
                        hit_next   = 1'b1;
                        hslot_next = rd_addr_reg;
                        hrank_next = rdata_reg.rank;
                    end
                    if (rd_addr_reg == '0 || rdata_reg.rank > worst_rank_reg)
                    begin
                        worst_idx_next  = rd_addr_reg;
                        worst_rank_next = rdata_reg.rank;
                    end
                end
            end
            ST_DECIDE:
            begin
                idx_next     = '0;
                evicted_next = !hit_reg && full;
                if (hit_reg)
                begin
                    slot_next  = hslot_reg;
                    limit_next = {1'b0, hrank_reg};
                end
                else
                begin
                    limit_next = CNT_W'(ENTRIES);
                    if (full)
                    begin
                        slot_next = worst_idx_reg;
                    end
                    else
                    begin
                        slot_next  = count_reg[IDX_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rvld_next    = 1'b1;
                    rd_addr_next = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
                if (rvld_reg)
                begin
                    wr_en = 1'b1;
                    if (rd_addr_reg == slot_reg)
                    begin
                        wr_data.rank = '0;
                        if (!hit_reg)
                        begin
                            wr_data.tag = page;
                        end
                    end
                    else if ({1'b0, rdata_reg.rank} < limit_reg)
                    begin
                        wr_data.rank = rdata_reg.rank + 1'b1;
                    end
                end
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_RESULT);
    assign hit         = hit_reg;
    assign vpn         = page;
    assign page_offset = addr_reg[OFFSET_W-1:0];
    assign evicted     = evicted_reg;
    assign slot        = slot_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above capacity");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && evicted |-> !hit && full)
        else $error("eviction without full store or on hit");

    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> {1'b0, slot} < count_reg)
        else $error("reported slot not a valid entry");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");
`endif

endmodule

// ----- tb/tb_tlb_lookup_lru_replace_core.sv -----
`timescale 1ns / 1ps

module tb_tlb_lookup_lru_replace_core;

    import tlru_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1930;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOT_PAGES    = 16;

    typedef struct {
        logic                hit;
        logic [PAGE_W-1:0]   vpn;
        logic [OFFSET_W-1:0] page_offset;
        logic                evicted;
        logic [IDX_W-1:0]    slot;
    } lookup_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [ADDR_W-1:0]   virtual_address = '0;
    logic                busy;
    logic                done;
    logic                hit;
    logic [PAGE_W-1:0]   vpn;
    logic [OFFSET_W-1:0] page_offset;
    logic                evicted;
    logic [IDX_W-1:0]    slot;

    logic [ADDR_W-1:0]   pending_addrs[$];
    lookup_result_t      expected_lookups[$];
    lookup_result_t      want;

    // shadow TLB state
    logic [PAGE_W-1:0]   shadow_tag[ENTRIES];
    int                  shadow_rank[ENTRIES];
    int                  shadow_count = 0;

    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    int                  lookups_sent = 0;
    int                  hit_count = 0;
    int                  fill_count = 0;
    int                  evict_count = 0;
    int                  gap_left = 0;
    int                  burst_left = 1;

    tlb_lookup_lru_replace_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .virtual_address (virtual_address),
        .done            (done),
        .hit             (hit),
        .vpn             (vpn),
        .page_offset     (page_offset),
        .evicted         (evicted),
        .slot            (slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // make s most recent; valid entries younger than limit age by one
    function automatic void age_entries(input int s, input int limit);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (i != s && shadow_rank[i] < limit)
                shadow_rank[i]++;
        end
        shadow_rank[s] = 0;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
        lookup_result_t r;
        logic [PAGE_W-1:0] page;
        int s;
        int oldest;
        page = addr[ADDR_W-1:OFFSET_W];
        r.hit = 1'b0;
        r.evicted = 1'b0;
        r.vpn = page;
        r.page_offset = addr[OFFSET_W-1:0];
        s = 0;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (!r.hit && shadow_tag[i] == page)
            begin
                r.hit = 1'b1;
                s = i;
            end
        end
        if (r.hit)
        begin
            age_entries(s, shadow_rank[s]);
            hit_count++;
        end
        else if (shadow_count < ENTRIES)
        begin
            s = shadow_count;
            shadow_tag[s] = page;
            shadow_rank[s] = 0;
            shadow_count++;
            age_entries(s, ENTRIES);
            fill_count++;
        end
        else
        begin
            oldest = 0;
            for (int i = 1; i < ENTRIES; i++)
            begin
                if (shadow_rank[i] > shadow_rank[oldest])
                    oldest = i;
            end
            s = oldest;
            shadow_tag[s] = page;
            r.evicted = 1'b1;
            age_entries(s, ENTRIES);
            evict_count++;
        end
        r.slot = IDX_W'(s);
        return r;
    endfunction

    // driver: bursts of items separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                expected_lookups.push_back(predict_lookup(virtual_address));
                lookups_sent++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_addrs.size() != 0)
            begin
                virtual_address <= pending_addrs.pop_front();
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0: gap_left <= 0;
                        1: gap_left <= $urandom_range(1, 3);
                        2: gap_left <= $urandom_range(1, 12);
                        default: gap_left <= $urandom_range(10, 30);
                    endcase
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every done pulse is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_lookups.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result page %h slot %0d",
                                          vpn, slot));
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b (page %h)",
                                              hit, want.hit, want.vpn));
                if (vpn !== want.vpn)
                    report_mismatch($sformatf("vpn %h, expected %h",
                                              vpn, want.vpn));
                if (page_offset !== want.page_offset)
                    report_mismatch($sformatf("page_offset %h, expected %h",
                                              page_offset, want.page_offset));
                if (evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %b, expected %b (page %h)",
                                              evicted, want.evicted, want.vpn));
                if (slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d (page %h)",
                                              slot, want.slot, want.vpn));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_lookups.size());
            $display("tlb_lookup_lru_replace_core test failed");
            $finish;
        end
    end

    initial
    begin
        logic [PAGE_W-1:0] hot[HOT_PAGES];
        logic [PAGE_W-1:0] page;
        int pool_size;

        // directed: field extremes, fill, hits on new and old entries, evictions
        pending_addrs.push_back(32'h0000_0000);
        pending_addrs.push_back(32'h0000_0ABC);
        pending_addrs.push_back(32'hFFFF_FFFF);
        pending_addrs.push_back(32'hFFFF_F000);
        pending_addrs.push_back(32'h1234_5678);
        pending_addrs.push_back(32'h8000_0000);
        pending_addrs.push_back(32'h7FFF_FFFF);
        pending_addrs.push_back(32'hAAAA_AAAA);
        pending_addrs.push_back(32'h5555_5555);
        pending_addrs.push_back(32'h0000_1FFF);
        pending_addrs.push_back(32'h8000_0123);
        pending_addrs.push_back(32'h0000_0000);
        pending_addrs.push_back(32'h0000_0FFF);
        pending_addrs.push_back(32'hDEAD_BEEF);
        pending_addrs.push_back(32'hFFFF_FABC);
        pending_addrs.push_back(32'h0BAD_F00D);
        pending_addrs.push_back(32'h1234_5000);
        pending_addrs.push_back(32'h0000_1000);
        pending_addrs.push_back(32'hDEAD_B000);

        // random: mostly a shifting working set, some cold pages
        for (int i = 0; i < HOT_PAGES; i++)
            hot[i] = PAGE_W'($urandom);
        pool_size = 6;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 80 == 0)
            begin
                pool_size = $urandom_range(1, HOT_PAGES);
                hot[$urandom_range(0, HOT_PAGES - 1)] = PAGE_W'($urandom);
                hot[$urandom_range(0, HOT_PAGES - 1)] = PAGE_W'($urandom);
            end
            if ($urandom_range(0, 99) < 75)
                page = hot[$urandom_range(0, pool_size - 1)];
            else
                page = PAGE_W'($urandom);
            pending_addrs.push_back({page, OFFSET_W'($urandom)});
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_addrs.size() != 0 || start)
            @(posedge clk);
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d lookups: %0d hits, %0d fills of empty slots, %0d LRU evictions",
                 lookups_sent, hit_count, fill_count, evict_count);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("tlb_lookup_lru_replace_core test passed");
        else
            $display("tlb_lookup_lru_replace_core test failed");
        $finish;
    end

endmodule
